### rtl/fht_pkg.sv
// ============================================================================
// fht_pkg: shared constants for the frequency histogram table
// Field widths, operation codes and default sizes used by the core and
// its channel interfaces.
// ============================================================================
package fht_pkg;

	// Fixed payload field widths
	localparam int FUNC_W = 2;
	localparam int KEY_W  = 10;
	localparam int FREQ_W = 10;

	// Default storage sizes
	localparam int DEF_KEY_BITS   = 10;
	localparam int DEF_COUNT_BITS = 10;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

endpackage

### rtl/fht_if.sv
// ============================================================================
// fht_if: request and response channels
// Valid/ready channels; a transfer happens on a rising edge with both high.
// ============================================================================

// Request channel: one operation per transfer
interface fht_req_if;
	logic                       valid;
	logic                       ready;
	logic [fht_pkg::FUNC_W-1:0] func;
	logic [fht_pkg::KEY_W-1:0]  key;
	logic [fht_pkg::FREQ_W-1:0] frequency;

	modport source (output valid, output func, output key, output frequency, input ready);
	modport sink   (input valid, input func, input key, input frequency, output ready);
endinterface

// Response channel: one query answer per transfer
interface fht_rsp_if;
	logic valid;
	logic ready;
	logic found;

	modport source (output valid, output found, input ready);
	modport sink   (input valid, input found, output ready);
endinterface

### rtl/frequency_histogram_table_core.sv
// ============================================================================
// frequency_histogram_table_core: per-key counts with a count histogram
// Insert/remove move a key between histogram bins; a query reports whether
// any key holds exactly the asked count.
// ============================================================================
// Sequencing: a query reads its histogram bin, then waits in ST_QRD until the
// output register is free; an insert or remove steps through ST_CNT, ST_HFROM
// and ST_HTO (only ST_CNT if the count is left unchanged). A new request is
// taken only once the last is through, set by the single shared step unit and
// the one read port of each memory. Reset: a clearing pass over 2^max(KEY_BITS,
// COUNT_BITS) addresses zeroes both memories; req.ready stays low until it ends.
module frequency_histogram_table_core #(
	parameter int KEY_BITS   = fht_pkg::DEF_KEY_BITS,
	parameter int COUNT_BITS = fht_pkg::DEF_COUNT_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	fht_req_if.sink   req,
	fht_rsp_if.source rsp
);
	import fht_pkg::*;

	localparam int KEY_DEPTH   = 1 << KEY_BITS;
	localparam int COUNT_DEPTH = 1 << COUNT_BITS;
	localparam int COUNT_MAX   = COUNT_DEPTH - 1;
	localparam int HIST_W      = KEY_BITS + 1;
	localparam int AW          = (COUNT_BITS > HIST_W) ? COUNT_BITS : HIST_W;
	localparam int CLR_BITS    = (KEY_BITS > COUNT_BITS) ? KEY_BITS : COUNT_BITS;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CNT,
		ST_HFROM,
		ST_HTO,
		ST_QRD
	} state_t;

	state_t                state_q;
	logic [CLR_BITS-1:0]   clr_q;
	logic [FUNC_W-1:0]     func_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [COUNT_BITS-1:0] old_q;
	logic [COUNT_BITS-1:0] new_q;
	logic                  freq_ok_q;
	logic                  valid_q;
	logic                  found_q;

	// Memories and their registered read data
	logic [COUNT_BITS-1:0] cnt_mem [KEY_DEPTH];
	logic [HIST_W-1:0]     hist_mem [COUNT_DEPTH];
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic [HIST_W-1:0]     hist_rd_q;

	logic                  cnt_re, cnt_we;
	logic [KEY_BITS-1:0]   cnt_wa;
	logic [COUNT_BITS-1:0] cnt_wd;
	logic                  hist_re, hist_we;
	logic [COUNT_BITS-1:0] hist_ra, hist_wa;
	logic [HIST_W-1:0]     hist_wd;

	logic                  accept;
	logic [KEY_BITS-1:0]   key_idx;
	logic [COUNT_BITS-1:0] freq_idx;
	logic                  freq_ok;
	logic                  is_update;
	logic                  cnt_skip;
	logic                  rsp_load;

	logic [AW-1:0]         alu_a;
	logic                  alu_dec;
	logic [AW-1:0]         alu_sum;
	logic                  alu_zero;

	// Request decode
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign key_idx   = KEY_BITS'(req.key);
	assign freq_idx  = COUNT_BITS'(req.frequency);
	assign freq_ok   = (req.frequency != '0) && (32'(req.frequency) <= 32'(COUNT_MAX));
	assign is_update = (req.func == FUNC_INSERT) || (req.func == FUNC_REMOVE);

	assign rsp.valid = valid_q;
	assign rsp.found = found_q;

	// Load a query answer once the output register is free
	assign rsp_load  = (state_q == ST_QRD) && (!valid_q || rsp.ready);

	// Shared step unit
	fht_step_unit #(
		.W (AW)
	) u_step (
		.a       (alu_a),
		.dec     (alu_dec),
		.sum     (alu_sum),
		.is_zero (alu_zero)
	);

	// Saturated insert or remove at zero leaves everything unchanged
	assign cnt_skip = (func_q == FUNC_INSERT) ? (32'(cnt_rd_q) == 32'(COUNT_MAX)) : alu_zero;

	// Select step operand and memory ports per sequencer step
	always_comb begin
		alu_a   = AW'(hist_rd_q);
		alu_dec = 1'b0;
		cnt_re  = 1'b0;
		cnt_we  = 1'b0;
		cnt_wa  = key_q;
		cnt_wd  = alu_sum[COUNT_BITS-1:0];
		hist_re = 1'b0;
		hist_ra = freq_idx;
		hist_we = 1'b0;
		hist_wa = old_q;
		hist_wd = alu_sum[HIST_W-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				cnt_we  = 1'b1;
				cnt_wa  = clr_q[KEY_BITS-1:0];
				cnt_wd  = '0;
				hist_we = 1'b1;
				hist_wa = clr_q[COUNT_BITS-1:0];
				hist_wd = '0;
			end
			ST_IDLE: begin
				cnt_re  = accept && is_update;
				hist_re = accept && (req.func == FUNC_QUERY);
				hist_ra = freq_idx;
			end
			ST_CNT: begin
				alu_a   = AW'(cnt_rd_q);
				alu_dec = (func_q == FUNC_REMOVE);
				cnt_we  = !cnt_skip;
				hist_re = !cnt_skip;
				hist_ra = cnt_rd_q;
			end
			ST_HFROM: begin
				alu_dec = 1'b1;
				hist_we = (old_q != '0) && !alu_zero;
				hist_wa = old_q;
				hist_re = 1'b1;
				hist_ra = new_q;
			end
			ST_HTO: begin
				hist_we = (new_q != '0);
				hist_wa = new_q;
			end
			ST_QRD: begin
				alu_a = AW'(hist_rd_q);
			end
			default: begin
				alu_a = AW'(hist_rd_q);
			end
		endcase
	end

	// Count memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (cnt_re) begin
			cnt_rd_q <= cnt_mem[key_idx];
		end
	end

	// Histogram memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_wa] <= hist_wd;
		end
		if (hist_re) begin
			hist_rd_q <= hist_mem[hist_ra];
		end
	end

	// Sequencer with registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			func_q    <= FUNC_INSERT;
			key_q     <= '0;
			old_q     <= '0;
			new_q     <= '0;
			freq_ok_q <= 1'b0;
			valid_q   <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			// Load a finished answer, drop it once transferred
			if (rsp_load) begin
				valid_q <= 1'b1;
				found_q <= freq_ok_q && !alu_zero;
			end else if (valid_q && rsp.ready) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CLR_BITS'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						func_q    <= req.func;
						key_q     <= key_idx;
						freq_ok_q <= freq_ok;
						if (is_update) begin
							state_q <= ST_CNT;
						end else if (req.func == FUNC_QUERY) begin
							state_q <= ST_QRD;
						end
					end
				end
				ST_CNT: begin
					old_q <= cnt_rd_q;
					new_q <= alu_sum[COUNT_BITS-1:0];
					state_q <= cnt_skip ? ST_IDLE : ST_HFROM;
				end
				ST_HFROM: begin
					state_q <= ST_HTO;
				end
				ST_HTO: begin
					state_q <= ST_IDLE;
				end
				ST_QRD: begin
					// Hold until the output register is free
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/fht_step_unit.sv
// ============================================================================
// fht_step_unit: shared increment/decrement unit
// Adds or subtracts one and flags a zero operand; reused for the key count
// and for both histogram bin updates.
// ============================================================================
module fht_step_unit #(
	parameter int W = 11
) (
	input  logic [W-1:0] a,
	input  logic         dec,
	output logic [W-1:0] sum,
	output logic         is_zero
);

	// Step the operand by one in either direction
	assign sum     = dec ? (a - W'(1)) : (a + W'(1));
	assign is_zero = (a == '0);

endmodule
